// ===== hw/rtl/periodic_timer_table_macros.svh =====
// ----------------------------------------------------------------------------
// periodic timer table assertion macros
// shared property wrappers, clocked on the rising edge and off during reset
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// types, constants and helpers shared by the periodic timer table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int NUM_TIMERS = 20;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int OPCODE_W   = 3;
   localparam int HANDLE_W   = 5;
   localparam int SLOT_W     = 5;
   localparam int PERIOD_W   = 16;
   localparam int NOW_W      = 31;
   localparam int DEADLINE_W = 32;

   localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOCATE   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ACTIVATE   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DEACTIVATE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_RELEASE    = 3'd4;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]   period;
      logic                  armed;
      logic [DEADLINE_W-1:0] deadline;
   } entry_type;

   typedef struct packed {
      logic      rd_en;
      idx_type   rd_addr;
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } push_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   function automatic logic handle_in_range(input logic [HANDLE_W-1:0] h);
      return (h != '0) && (32'(h) <= NUM_TIMERS);
   endfunction

   function automatic idx_type handle_to_index(input logic [HANDLE_W-1:0] h);
      logic [IDX_W+HANDLE_W-1:0] t;
      t = {{IDX_W{1'b0}}, h} - (IDX_W+HANDLE_W)'(1);
      return IDX_W'(t);
   endfunction

   function automatic logic [SLOT_W-1:0] index_to_slot(input idx_type idx);
      logic [IDX_W:0] t;
      t = {1'b0, idx} + (IDX_W+1)'(1);
      return SLOT_W'(t);
   endfunction

endpackage

// ===== hw/rtl/ptt_mem.sv =====
// ----------------------------------------------------------------------------
// ptt_mem
// timer slot store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  ptt_pkg::mem_req_type mem_req,
   output ptt_pkg::entry_type   rd_data
);
   import ptt_pkg::*;

   entry_type mem_ff [NUM_TIMERS];
   logic      valid_ff [NUM_TIMERS];
   entry_type rd_data_ff;
   logic      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   // an entry never written reads as a free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/ptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptt_ctrl
// command sequencer: reads a slot, updates it and writes it back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_timer_table_macros.svh"

module ptt_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ptt_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [ptt_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [ptt_pkg::PERIOD_W-1:0]   req_period,
   input  logic                           req_event_valid,
   input  logic [ptt_pkg::NOW_W-1:0]      req_now,
   input  ptt_pkg::entry_type             rd_data,
   output ptt_pkg::mem_req_type           mem_req,
   output ptt_pkg::push_type              push,
   input  logic                           push_ready
);
   import ptt_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   idx_type               idx_ff, idx_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [NOW_W-1:0]      now_ff, now_in;
   logic                  res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;

   logic [DEADLINE_W-1:0] now_ext;
   logic [DEADLINE_W-1:0] next_deadline;
   logic                  fire;
   logic                  last_idx;
   logic                  slot_used;
   logic [PERIOD_W-1:0]   alloc_period;
   logic [SLOT_W-1:0]     cur_slot;

   assign now_ext       = {1'b0, now_ff};
   assign next_deadline = now_ext + {{(DEADLINE_W-PERIOD_W){1'b0}}, rd_data.period};
   assign fire          = rd_data.armed && (now_ext >= rd_data.deadline);
   assign last_idx      = (idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign slot_used     = (rd_data.period != '0);
   assign alloc_period  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign cur_slot      = index_to_slot(idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         res_ok_ff   <= 1'b0;
         res_slot_ff <= '0;
      end else begin
         state_ff    <= state_in;
         res_ok_ff   <= res_ok_in;
         res_slot_ff <= res_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      period_ff <= period_in;
      now_ff    <= now_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      period_in   = period_ff;
      now_in      = now_ff;
      res_ok_in   = res_ok_ff;
      res_slot_in = res_slot_ff;
      req_stall   = 1'b1;
      mem_req     = '0;
      push        = '0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in       = req_opcode;
               period_in   = req_period;
               now_in      = req_now;
               res_ok_in   = 1'b0;
               res_slot_in = '0;
               state_in    = ST_FINISH;
               case (req_opcode)
                  OP_TICK: begin
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  OP_ALLOCATE: begin
                     idx_in = '0;
                     if (req_event_valid) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_ACTIVATE, OP_DEACTIVATE, OP_RELEASE: begin
                     idx_in = handle_to_index(req_handle);
                     if (handle_in_range(req_handle)) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     idx_in = '0;
                  end
               endcase
               mem_req.rd_en   = (state_in == ST_SCAN);
               mem_req.rd_addr = idx_in;
            end
         end

         ST_SCAN: begin
            mem_req.wr_addr = idx_ff;
            case (op_ff)
               OP_TICK: begin
                  // a fired slot is held back until the next one shows whether it is last
                  if (!(fire && res_ok_ff && !push_ready)) begin
                     if (fire) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = '{period: rd_data.period, armed: 1'b1,
                                            deadline: next_deadline};
                        push.valid  = res_ok_ff;
                        push.ok     = 1'b1;
                        push.slot   = res_slot_ff;
                        push.last   = 1'b0;
                        res_ok_in   = 1'b1;
                        res_slot_in = cur_slot;
                     end
                     if (last_idx) begin
                        state_in = ST_FINISH;
                     end else begin
                        idx_in          = idx_ff + IDX_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_in;
                     end
                  end
               end
               OP_ALLOCATE: begin
                  if (!slot_used) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = '{period: alloc_period, armed: 1'b0, deadline: '0};
                     res_ok_in       = 1'b1;
                     res_slot_in     = cur_slot;
                     state_in        = ST_FINISH;
                  end else if (last_idx) begin
                     state_in = ST_FINISH;
                  end else begin
                     idx_in          = idx_ff + IDX_W'(1);
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = idx_in;
                  end
               end
               OP_ACTIVATE: begin
                  if (slot_used && !rd_data.armed) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = '{period: rd_data.period, armed: 1'b1,
                                         deadline: next_deadline};
                     res_ok_in       = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
               OP_DEACTIVATE: begin
                  if (slot_used && rd_data.armed) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = '{period: rd_data.period, armed: 1'b0, deadline: '0};
                     res_ok_in       = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
               OP_RELEASE: begin
                  if (slot_used) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = '0;
                     res_ok_in       = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_FINISH: begin
            push.valid = push_ready;
            push.ok    = res_ok_ff;
            push.slot  = res_ok_ff ? res_slot_ff : '0;
            push.last  = 1'b1;
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PTT_ASSERT_IMPL(a_write_only_in_scan, clock, reset, mem_req.wr_en, state_ff == ST_SCAN, "slot write outside scan")
   `PTT_ASSERT_IMPL(a_mid_result_from_tick, clock, reset, push.valid && !push.last, (state_ff == ST_SCAN) && (op_ff == OP_TICK), "non-final result outside a tick scan")
   `PTT_ASSERT_NEXT(a_last_returns_idle, clock, reset, push.valid && push.last, state_ff == ST_IDLE, "final result did not return to idle")
   `PTT_ASSERT_NEXT(a_single_slot_ops, clock, reset, (state_ff == ST_SCAN) && (op_ff != OP_TICK) && (op_ff != OP_ALLOCATE), state_ff == ST_FINISH, "handle command took more than one slot")

endmodule

// ===== hw/rtl/periodic_timer_table.sv =====
// tick: scans every slot, one per cycle unless a fired slot waits on the output register
// allocate: stops at the first free slot, or after the last slot when none is free
// activate, deactivate, release: one slot; bad handle, no event or unknown opcode: no slot
// one command at a time: the next transfer is taken right after the final result is
// registered, so output stalls hold back both the results and the next transfer
// reset is synchronous; slot valid bits clear at once, so every slot reads free
// ----------------------------------------------------------------------------
// periodic_timer_table
// pool of periodic timers with allocate, arm, disarm, free and tick commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_timer_table_macros.svh"

module periodic_timer_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ptt_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ptt_pkg::HANDLE_W-1:0] req_handle,
   input  logic [ptt_pkg::PERIOD_W-1:0] req_period,
   input  logic                         req_event_valid,
   input  logic [ptt_pkg::NOW_W-1:0]    req_now,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [ptt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_last
);
   import ptt_pkg::*;

   mem_req_type       mem_req;
   entry_type         rd_data;
   push_type          push;
   logic              push_ready;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_last_ff, rsp_last_in;

   ptt_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ptt_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_handle      (req_handle),
      .req_period      (req_period),
      .req_event_valid (req_event_valid),
      .req_now         (req_now),
      .rd_data         (rd_data),
      .mem_req         (mem_req),
      .push            (push),
      .push_ready      (push_ready)
   );

   // output register frees up in the same cycle its transfer completes
   assign push_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = push.ok;
         rsp_slot_in  = push.slot;
         rsp_last_in  = push.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_last  = rsp_last_ff;

   `PTT_ASSERT_IMPL(a_push_only_when_free, clock, reset, push.valid, push_ready,
                    "result pushed into an occupied output register")

endmodule
